>>> hw/rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the pulse period tachometer
// Sequencer states, field widths and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

   localparam int unsigned TIME_BITS_DEF = 48;

   localparam int unsigned CNT_W    = 14;  // edge count per sample
   localparam int unsigned EPR_W    = 12;  // edges per revolution register
   localparam int unsigned RPM_W    = 14;  // speed result
   localparam int unsigned PERIOD_W = 26;  // a period of at most one minute in us
   localparam int unsigned PROD_W   = PERIOD_W + EPR_W;
   localparam int unsigned DVS_W    = (PROD_W > CNT_W) ? PROD_W : CNT_W;

   localparam logic [PERIOD_W-1:0] US_PER_MINUTE = PERIOD_W'(60000000);
   localparam logic [RPM_W-1:0]    MAX_RPM       = RPM_W'(10000);
   localparam logic [EPR_W-1:0]    EPR_RESET     = EPR_W'(120);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_PERIOD,
      ST_MUL,
      ST_PROD,
      ST_DIV_RPM,
      ST_OUT
   } state_type;

endpackage : ppt_pkg

`default_nettype wire

>>> hw/rtl/pulse_period_tachometer_core.sv
// ----------------------------------------------------------------------------
// pulse_period_tachometer_core: shaft speed from timestamped edge counts
// Per request: period = elapsed / edges, rpm = 60e6 / (period * edges_per_rev).
// ----------------------------------------------------------------------------
// A request with edges runs through ST_DIV_PERIOD, ST_MUL, ST_PROD, ST_DIV_RPM and
// ST_OUT, and the next request is taken only back in ST_IDLE:
// one shared restoring divider produces one quotient bit per cycle and runs twice,
// first for the mean period per edge and then for the speed, with a registered
// period * edges_per_rev multiply in between. A request with zero edges skips both
// divisions and goes straight to ST_OUT. A period beyond one minute or a zero
// product skips only the second division. The result sits in an output register,
// so a new request is taken while it waits; a second finished result holds the
// input until the first is accepted. The edges_per_rev register is written
// through the csr channel, which is always ready.
`default_nettype none

module pulse_period_tachometer_core
   import ppt_pkg::*;
#(
   parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [TIME_BITS-1:0] req_now_us,
   input  wire logic [CNT_W-1:0]     req_pulse_count,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [RPM_W-1:0]          rsp_rpm,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [EPR_W-1:0]     csr_edges_per_rev
);

   localparam logic [TIME_BITS-1:0] MINUTE_T =
      {{(TIME_BITS - PERIOD_W){1'b0}}, US_PER_MINUTE};

   state_type state_ff, state_in;

   logic [EPR_W-1:0]     epr_ff, epr_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [RPM_W-1:0]     res_ff, res_in;
   logic [RPM_W-1:0]     rpm_ff, rpm_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_take;
   logic                 res_load;
   logic                 out_load;
   logic                 div_start;
   logic                 div_done;
   logic [TIME_BITS-1:0] div_dividend;
   logic [DVS_W-1:0]     div_divisor;
   logic [TIME_BITS-1:0] div_quo;
   logic [TIME_BITS-1:0] elapsed;

   assign elapsed  = req_now_us - last_ff;
   assign req_take = req_valid & req_ready;

   // the first run divides elapsed time by edges, the second a minute by the product
   assign div_dividend = (state_ff == ST_IDLE) ? elapsed : MINUTE_T;
   assign div_divisor  = (state_ff == ST_IDLE) ? DVS_W'(req_pulse_count)
                                               : DVS_W'(prod_ff);

   ppt_div #(
      .DIVIDEND_W (TIME_BITS),
      .DIVISOR_W  (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_pulse_count == '0) ? ST_OUT : ST_DIV_PERIOD;
            end
         end
         ST_DIV_PERIOD: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = (div_quo > MINUTE_T) ? ST_OUT : ST_PROD;
         end
         ST_PROD: begin
            state_in = (prod_ff == '0) ? ST_OUT : ST_DIV_RPM;
         end
         ST_DIV_RPM: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      res_load  = 1'b0;
      res_in    = res_ff;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_valid && (req_pulse_count != '0);
            res_load  = 1'b1;
            res_in    = '0;
         end
         ST_DIV_PERIOD: begin
         end
         ST_MUL: begin
            // period longer than a minute: drop to zero unless the divisor is zero
            res_load = 1'b1;
            res_in   = (epr_ff == '0) ? MAX_RPM : '0;
         end
         ST_PROD: begin
            div_start = (prod_ff != '0);
            res_load  = 1'b1;
            res_in    = MAX_RPM;
         end
         ST_DIV_RPM: begin
            res_load = div_done;
            res_in   = (div_quo > TIME_BITS'(MAX_RPM)) ? MAX_RPM : div_quo[RPM_W-1:0];
         end
         ST_OUT: begin
            out_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      epr_in       = (csr_valid && csr_ready) ? csr_edges_per_rev : epr_ff;
      last_in      = req_take ? req_now_us : last_ff;
      prod_in      = PROD_W'(div_quo[PERIOD_W-1:0]) * PROD_W'(epr_ff);
      rpm_in       = out_load ? res_ff : rpm_ff;
      rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         epr_ff       <= EPR_RESET;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         epr_ff       <= epr_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
      if (res_load) begin
         res_ff <= res_in;
      end
      rpm_ff <= rpm_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rpm   = rpm_ff;

   a_rpm_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rpm_ff <= MAX_RPM))
      else $error("rpm above saturation limit");

   a_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_PERIOD || state_ff == ST_DIV_RPM))
      else $error("divider finished outside a divide state");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request taken twice back to back");

endmodule : pulse_period_tachometer_core

`default_nettype wire

>>> hw/rtl/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div: shared restoring divider
// One quotient bit per cycle from start to done.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_div
   import ppt_pkg::*;
#(
   parameter int unsigned DIVIDEND_W = TIME_BITS_DEF,
   parameter int unsigned DIVISOR_W  = DVS_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int unsigned CNT_BITS = $clog2(DIVIDEND_W);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0] shifted;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = ~diff[DIVISOR_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit into the remainder, subtract if it fits
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a run");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule : ppt_div

`default_nettype wire

>>> bench/tb_pulse_period_tachometer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_period_tachometer_core: self-checking bench for the tachometer core
// A stimulus table covers edge cases, some with known speeds. Random phases
// follow, each with its own edges_per_rev setting. Every response is checked
// against a known speed or an in-bench model; both sides stall at random.
// ----------------------------------------------------------------------------

module tb_pulse_period_tachometer_core
   import ppt_pkg::*;
;

   localparam int unsigned TBITS          = TIME_BITS_DEF;
   localparam int unsigned PHASE_COUNT    = 8;
   localparam int unsigned PHASE_ITEMS    = 144;
   localparam int unsigned HOLD_OFF_LEN   = 600;
   localparam int unsigned DIRECTED_ROWS  = 28;

   typedef struct packed {
      logic             csr_write;
      logic [EPR_W-1:0] epr;
      logic [TBITS-1:0] now;
      logic [CNT_W-1:0] count;
      logic             known;
      logic [RPM_W-1:0] rpm;
   } sample_row_type;

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_ready;
   logic [TBITS-1:0]    req_now_us        = '0;
   logic [CNT_W-1:0]    req_pulse_count   = '0;
   logic                rsp_valid;
   logic                rsp_ready         = 1'b0;
   logic [RPM_W-1:0]    rsp_rpm;
   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic [EPR_W-1:0]    csr_edges_per_rev = '0;

   // speed model state
   logic [TBITS-1:0]    tacho_last_us;
   logic [EPR_W-1:0]    tacho_edges_per_rev;
   logic [RPM_W-1:0]    rpm_expected_q[$];

   int unsigned         mismatch_count    = 0;
   bit                  sender_idle_on    = 1'b1;
   bit                  receiver_idle_on  = 1'b1;
   bit                  hold_off_request  = 1'b0;

   sample_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{1'b0, 12'd0,    48'd0,               14'd0,     1'b1, 14'd0},
      '{1'b0, 12'd0,    48'd0,               14'd1,     1'b1, 14'd10000},
      '{1'b0, 12'd0,    48'd500,             14'd1,     1'b1, 14'd1000},
      '{1'b0, 12'd0,    48'd1000,            14'd10000, 1'b1, 14'd10000},
      '{1'b0, 12'd0,    48'd60001000,        14'd1,     1'b1, 14'd0},
      '{1'b0, 12'd0,    48'd120001001,       14'd1,     1'b1, 14'd0},
      '{1'b0, 12'd0,    48'd120001051,       14'd1,     1'b1, 14'd10000},
      '{1'b0, 12'd0,    48'd120001100,       14'd1,     1'b1, 14'd10000},
      '{1'b0, 12'd0,    48'd120001151,       14'd1,     1'b0, 14'd0},
      '{1'b0, 12'd0,    48'd121001151,       14'd10000, 1'b1, 14'd5000},
      '{1'b0, 12'd0,    48'hFFFF_FFFF_FFFF,  14'd8191,  1'b0, 14'd0},
      '{1'b0, 12'd0,    48'h0000_0000_1000,  14'd1,     1'b0, 14'd0},
      '{1'b0, 12'd0,    48'h5555_5555_5555,  14'd5461,  1'b0, 14'd0},
      '{1'b0, 12'd0,    48'hAAAA_AAAA_AAAA,  14'd2730,  1'b0, 14'd0},
      '{1'b0, 12'd0,    48'hAAAA_AAAA_AAAA,  14'd0,     1'b1, 14'd0},
      '{1'b1, 12'd0,    48'd0,               14'd0,     1'b0, 14'd0},
      '{1'b0, 12'd0,    48'hAAAA_AAAA_AB0E,  14'd1,     1'b1, 14'd10000},
      '{1'b0, 12'd0,    48'hAAAA_AED6_C88E,  14'd1,     1'b1, 14'd10000},
      '{1'b0, 12'd0,    48'hAAAA_AED6_C88E,  14'd0,     1'b1, 14'd0},
      '{1'b1, 12'd1,    48'd0,               14'd0,     1'b0, 14'd0},
      '{1'b0, 12'd0,    48'hAAAA_AED6_DFFE,  14'd1,     1'b1, 14'd10000},
      '{1'b0, 12'd0,    48'hAAAA_B26A_66FE,  14'd1,     1'b1, 14'd1},
      '{1'b1, 12'd2048, 48'd0,               14'd0,     1'b0, 14'd0},
      '{1'b0, 12'd0,    48'hAAAA_B26A_726F,  14'd1,     1'b1, 14'd10},
      '{1'b1, 12'd4095, 48'd0,               14'd0,     1'b0, 14'd0},
      '{1'b0, 12'd0,    48'hFFFF_FFFF_FFFF,  14'd1,     1'b0, 14'd0},
      '{1'b0, 12'd0,    48'd0,               14'd1,     1'b1, 14'd10000},
      '{1'b1, 12'd120,  48'd0,               14'd0,     1'b0, 14'd0}
   };

   pulse_period_tachometer_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_now_us        (req_now_us),
      .req_pulse_count   (req_pulse_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rpm           (rsp_rpm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_edges_per_rev (csr_edges_per_rev)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [RPM_W-1:0] rpm_from_elapsed(input logic [TBITS-1:0] elapsed,
                                                         input logic [CNT_W-1:0] count,
                                                         input logic [EPR_W-1:0] epr);
      logic [TBITS-1:0] period;
      logic [63:0]      divisor;
      logic [63:0]      quotient;
      if (count == '0) begin
         return '0;
      end
      period = elapsed / count;
      // beyond one minute per edge the quotient is zero unless the divisor is
      if (64'(period) > 64'(US_PER_MINUTE)) begin
         return (epr == '0) ? MAX_RPM : '0;
      end
      divisor = 64'(period) * 64'(epr);
      if (divisor == 64'd0) begin
         return MAX_RPM;
      end
      quotient = 64'(US_PER_MINUTE) / divisor;
      if (quotient > 64'(MAX_RPM)) begin
         quotient = 64'(MAX_RPM);
      end
      return quotient[RPM_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [RPM_W-1:0] got,
                                  input logic [RPM_W-1:0] want);
      $display("mismatch: %s rpm got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Offer one request and hold it until accepted; valid stays high afterwards.
   task automatic send_sample(input logic [TBITS-1:0] now, input logic [CNT_W-1:0] count,
                              input bit known, input logic [RPM_W-1:0] known_rpm);
      logic [RPM_W-1:0] rpm;
      req_valid       <= 1'b1;
      req_now_us      <= now;
      req_pulse_count <= count;
      do @(posedge clock); while (!req_ready);
      rpm = rpm_from_elapsed(now - tacho_last_us, count, tacho_edges_per_rev);
      tacho_last_us = now;
      rpm_expected_q.push_back(known ? known_rpm : rpm);
   endtask

   task automatic pause_req(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         pause_req($urandom_range(1, 18));
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (rpm_expected_q.size() != 0);
   endtask

   task automatic write_edges_per_rev(input logic [EPR_W-1:0] value);
      csr_valid         <= 1'b1;
      csr_edges_per_rev <= value;
      do @(posedge clock); while (!csr_ready);
      tacho_edges_per_rev = value;
      csr_valid <= 1'b0;
   endtask

   task automatic make_random_sample(output logic [TBITS-1:0] now,
                                     output logic [CNT_W-1:0] count);
      int unsigned pick;
      int unsigned period;
      logic [63:0] elapsed;
      pick    = $urandom_range(0, 99);
      count   = CNT_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 10000 : 64));
      elapsed = '0;
      if (pick < 55) begin
         // realistic speeds: spread the period over many octaves
         period  = $urandom_range(0, 1 << $urandom_range(0, 26));
         elapsed = 64'(period) * 64'(count) + 64'($urandom_range(0, count - 1));
      end else if (pick < 65) begin
         count   = '0;
         elapsed = 64'($urandom_range(0, 1 << 20));
      end else if (pick < 75) begin
         elapsed = 64'($urandom_range(0, count - 1));
      end else if (pick < 85) begin
         count   = CNT_W'($urandom_range(1, 16));
         elapsed = {$urandom, $urandom};
      end else if (pick < 93) begin
         count   = CNT_W'($urandom_range(0, 10000));
         elapsed = {$urandom, $urandom};
      end else begin
         // period right around one minute
         count   = CNT_W'($urandom_range(1, 3));
         period  = 60000000 + $urandom_range(0, 2) - 1;
         elapsed = 64'(period) * 64'(count) + 64'($urandom_range(0, count - 1));
      end
      now = tacho_last_us + elapsed[TBITS-1:0];
   endtask

   // response side: random stalls and one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rpm_expected_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_rpm, '0);
         end else if (rsp_rpm !== rpm_expected_q[0]) begin
            report_mismatch("wrong speed", rsp_rpm, rpm_expected_q.pop_front());
         end else begin
            void'(rpm_expected_q.pop_front());
         end
      end
   end

   initial begin
      logic [TBITS-1:0] now;
      logic [CNT_W-1:0] count;
      logic [EPR_W-1:0] epr_plan [0:PHASE_COUNT-1];

      epr_plan = '{12'd120, 12'd1, 12'd2048, 12'd33, 12'd0, 12'd4095, 12'd1000, 12'd0};
      epr_plan[PHASE_COUNT-1] = EPR_W'($urandom_range(1, 2048));
      tacho_last_us       = '0;
      tacho_edges_per_rev = EPR_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].csr_write) begin
            drain_responses();
            write_edges_per_rev(directed_rows[r].epr);
         end else begin
            send_sample(directed_rows[r].now, directed_rows[r].count,
                        directed_rows[r].known, directed_rows[r].rpm);
            maybe_pause();
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_responses();
         write_edges_per_rev(epr_plan[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == PHASE_COUNT - 1) begin
               sender_idle_on   = 1'b0;
               receiver_idle_on = 1'b0;
            end else begin
               sender_idle_on   = ((i / 40) % 3) != 2;
               receiver_idle_on = ((i / 40) % 3) != 1;
            end
            // stall the response side long enough to back up the input
            if (p == 1 && i == 40) begin
               hold_off_request = 1'b1;
            end
            make_random_sample(now, count);
            send_sample(now, count, 1'b0, '0);
            maybe_pause();
         end
      end

      drain_responses();
      repeat (250) @(posedge clock);
      if (rpm_expected_q.size() != 0) begin
         report_mismatch("missing response", '0, rpm_expected_q[0]);
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
